// ----- rtl/tsmjd_pkg.sv -----
// shared types and constants of the timestamp to mjd minutes converter
`default_nettype none
package tsmjd_pkg;

	localparam int unsigned POS_W = 5;
	localparam logic [POS_W-1:0] POS_SAT = 5'd25;
	localparam logic [POS_W-1:0] MIN_LEN = 5'd19;
	localparam int unsigned FIFO_DEPTH = 2;

	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// one parsed timestamp, handed from the parser to the arithmetic
	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic        off_present;
		logic        off_neg;
		logic [6:0]  off_hour;
		logic [6:0]  off_minute;
		logic        bad;
	} rec_t;

	typedef struct packed {
		logic valid;
		rec_t rec;
	} job_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// acc*10 + digit, kept to seven bits
	function automatic logic [6:0] push7(input logic [6:0] acc, input logic [7:0] c);
		logic [10:0] t;
		t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {7'b0000000, c[3:0]};
		return t[6:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/iso8601_timestamp_to_mjd_minutes.sv -----
// Timestamp text (YYYY-MM-DDTHH:MM:SS[+-HH:MM]) to UTC minutes since the MJD epoch.
// Input channel: one text byte per request on ch, last_char marks the final byte.
// A byte is taken at a clock edge with push high and full low; the parser takes
// one byte per cycle and only stalls when its two-entry hand-off queue is full.
// Result channel: a queue read side; while empty is low, utc_minutes and malformed
// hold the oldest result, and it is taken at an edge with pop high and empty low.
// One result per timestamp, produced on its final byte; malformed texts give
// malformed=1 and utc_minutes=0.
// The edge that takes the final byte writes the parsed timestamp into the queue;
// when the arithmetic is free, the arithmetic sequencer loads it and runs its steps.
// The steps are load, two multiply steps, reciprocal correction, day sum and scale
// to minutes, after which empty goes low; no new timestamp is loaded before that.
// While the receiver keeps up, texts of 19 bytes or more never wait.
// If the receiver stalls, one result stays in the output register, up to two parsed
// timestamps wait in the queue, and then full rises until pop frees space.
// Reset (arst_n low) clears the parser and the queue, and empties the output register.
`default_nettype none
module iso8601_timestamp_to_mjd_minutes (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [7:0]         ch,
	input  wire logic               last_char,
	input  wire logic               push,
	output logic                    full,
	output logic signed [33:0]      utc_minutes,
	output logic                    malformed,
	output logic                    empty,
	input  wire logic               pop
);

	tsmjd_pkg::job_t wr_job, rd_job;
	logic            accept;
	logic            q_full;
	logic            job_pop;

	assign full = q_full;
	assign accept = push && !q_full;

	tsmjd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ch        (ch),
		.last_char (last_char),
		.accept    (accept),
		.job       (wr_job)
	);

	tsmjd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr_job),
		.full   (q_full),
		.rd     (rd_job),
		.rd_pop (job_pop)
	);

	tsmjd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (rd_job),
		.job_pop     (job_pop),
		.empty       (empty),
		.pop         (pop),
		.utc_minutes (utc_minutes),
		.malformed   (malformed)
	);

endmodule
`default_nettype wire

// ----- rtl/tsmjd_front.sv -----
// character parser: checks the layout except the seconds digits and accumulates the digit fields
`default_nettype none
module tsmjd_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     ch,
	input  wire logic           last_char,
	input  wire logic           accept,
	output tsmjd_pkg::job_t     job
);

	logic [4:0]  pos_q, pos_n;
	logic [13:0] year_q, year_n;
	logic [6:0]  month_q, month_n, day_q, day_n, hour_q, hour_n, minute_q, minute_n;
	logic        off_present_q, off_present_n, off_neg_q, off_neg_n;
	logic [6:0]  off_hour_q, off_hour_n, off_minute_q, off_minute_n;
	logic        bad_q, bad_n;
	logic [16:0] year_t;
	logic        dig;

	assign dig = tsmjd_pkg::is_dec(ch);
	assign year_t = {year_q, 3'b000} + {2'b00, year_q, 1'b0} + {13'b0, ch[3:0]};

	always_comb begin
		year_n = year_q;
		month_n = month_q;
		day_n = day_q;
		hour_n = hour_q;
		minute_n = minute_q;
		off_present_n = off_present_q;
		off_neg_n = off_neg_q;
		off_hour_n = off_hour_q;
		off_minute_n = off_minute_q;
		bad_n = bad_q;
		if (pos_q <= 5'd3) begin
			if (dig) year_n = year_t[13:0];
			else bad_n = 1'b1;
		end else if (pos_q inside {5'd4, 5'd7}) begin
			if (ch != tsmjd_pkg::CH_DASH) bad_n = 1'b1;
		end else if (pos_q inside {5'd5, 5'd6}) begin
			if (dig) month_n = tsmjd_pkg::push7(month_q, ch);
			else bad_n = 1'b1;
		end else if (pos_q inside {5'd8, 5'd9}) begin
			if (dig) day_n = tsmjd_pkg::push7(day_q, ch);
			else bad_n = 1'b1;
		end else if (pos_q == 5'd10) begin
			if (ch != tsmjd_pkg::CH_T) bad_n = 1'b1;
		end else if (pos_q inside {5'd11, 5'd12}) begin
			if (dig) hour_n = tsmjd_pkg::push7(hour_q, ch);
			else bad_n = 1'b1;
		end else if (pos_q inside {5'd13, 5'd16}) begin
			if (ch != tsmjd_pkg::CH_COLON) bad_n = 1'b1;
		end else if (pos_q inside {5'd14, 5'd15}) begin
			if (dig) minute_n = tsmjd_pkg::push7(minute_q, ch);
			else bad_n = 1'b1;
		end else if (pos_q == 5'd19) begin
			if (ch == tsmjd_pkg::CH_PLUS || ch == tsmjd_pkg::CH_MINUS) begin
				off_present_n = 1'b1;
				off_neg_n = (ch == tsmjd_pkg::CH_MINUS);
			end
		end else if (off_present_q && (pos_q inside {5'd20, 5'd21})) begin
			if (dig) off_hour_n = tsmjd_pkg::push7(off_hour_q, ch);
			else bad_n = 1'b1;
		end else if (off_present_q && pos_q == 5'd22) begin
			if (ch != tsmjd_pkg::CH_COLON) bad_n = 1'b1;
		end else if (off_present_q && (pos_q inside {5'd23, 5'd24})) begin
			if (dig) off_minute_n = tsmjd_pkg::push7(off_minute_q, ch);
			else bad_n = 1'b1;
		end
		pos_n = (pos_q < tsmjd_pkg::POS_SAT) ? pos_q + 5'd1 : pos_q;
	end

	always_comb begin
		job.valid = accept && last_char;
		job.rec.year = year_n;
		job.rec.month = month_n;
		job.rec.day = day_n;
		job.rec.hour = hour_n;
		job.rec.minute = minute_n;
		job.rec.off_present = off_present_n;
		job.rec.off_neg = off_neg_n;
		job.rec.off_hour = off_hour_n;
		job.rec.off_minute = off_minute_n;
		// short text or a cut-off offset counts as malformed
		job.rec.bad = bad_n || (pos_n < tsmjd_pkg::MIN_LEN) ||
			(off_present_n && (pos_n < tsmjd_pkg::POS_SAT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			year_q <= '0;
			month_q <= '0;
			day_q <= '0;
			hour_q <= '0;
			minute_q <= '0;
			off_present_q <= 1'b0;
			off_neg_q <= 1'b0;
			off_hour_q <= '0;
			off_minute_q <= '0;
			bad_q <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				pos_q <= '0;
				year_q <= '0;
				month_q <= '0;
				day_q <= '0;
				hour_q <= '0;
				minute_q <= '0;
				off_present_q <= 1'b0;
				off_neg_q <= 1'b0;
				off_hour_q <= '0;
				off_minute_q <= '0;
				bad_q <= 1'b0;
			end else begin
				pos_q <= pos_n;
				year_q <= year_n;
				month_q <= month_n;
				day_q <= day_n;
				hour_q <= hour_n;
				minute_q <= minute_n;
				off_present_q <= off_present_n;
				off_neg_q <= off_neg_n;
				off_hour_q <= off_hour_n;
				off_minute_q <= off_minute_n;
				bad_q <= bad_n;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/tsmjd_fifo.sv -----
// two-entry queue of parsed timestamps between parser and arithmetic
`default_nettype none
module tsmjd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tsmjd_pkg::job_t wr,
	output logic                full,
	output tsmjd_pkg::job_t     rd,
	input  wire logic           rd_pop
);

	tsmjd_pkg::rec_t mem_q [tsmjd_pkg::FIFO_DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign full = (count_q == 2'(tsmjd_pkg::FIFO_DEPTH));
	assign do_push = wr.valid && !full;
	assign do_pop = rd_pop && (count_q != 2'd0);
	assign rd.valid = (count_q != 2'd0);
	assign rd.rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr.rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(tsmjd_pkg::FIFO_DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- rtl/tsmjd_back.sv -----
// date arithmetic sequencer and result register
`default_nettype none
module tsmjd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tsmjd_pkg::job_t    job,
	output logic                    job_pop,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [33:0]      utc_minutes,
	output logic                    malformed
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_FIX   = 3'd3;
	localparam logic [2:0] ST_SUM   = 3'd4;
	localparam logic [2:0] ST_SCALE = 3'd5;

	logic [2:0]         step_q;
	logic               out_vld_q;
	logic               bad_q;
	logic signed [33:0] utc_q;
	logic signed [15:0] yd_q;
	logic [7:0]         mm1_q;
	logic [6:0]         day_q;
	logic signed [14:0] tod_q;
	logic signed [26:0] pa_q;
	logic [25:0]        pb_q;
	logic signed [24:0] a_q;
	logic [11:0]        qe_q;
	logic [11:0]        b_q;
	logic signed [24:0] mjd_q;

	logic               start;
	logic               le2;
	logic signed [15:0] yd_n;
	logic [7:0]         mm1_n;
	logic [12:0]        local_min, off_mag;
	logic signed [14:0] off_s, tod_n;
	logic signed [26:0] a_full;
	logic [38:0]        recip;
	logic [25:0]        qd, rem;
	logic signed [35:0] tot;

	assign start = (step_q == ST_IDLE) && job.valid && (!out_vld_q || pop);
	assign job_pop = start;

	always_comb begin
		le2 = (job.rec.month <= 7'd2);
		// january and february count as months 13 and 14 of the year before
		yd_n = $signed({2'b00, job.rec.year}) - $signed({15'b0, le2}) - 16'sd1900;
		mm1_n = {1'b0, job.rec.month} + (le2 ? 8'd13 : 8'd1);
		local_min = {6'b0, job.rec.hour} * 13'd60 + {6'b0, job.rec.minute};
		off_mag = {6'b0, job.rec.off_hour} * 13'd60 + {6'b0, job.rec.off_minute};
		if (!job.rec.off_present) off_s = '0;
		else if (job.rec.off_neg) off_s = -$signed({2'b00, off_mag});
		else off_s = $signed({2'b00, off_mag});
		tod_n = $signed({2'b00, local_min}) - off_s;
		// truncation toward zero for the quarter-day year term
		a_full = (pa_q + (pa_q[26] ? 27'sd3 : 27'sd0)) >>> 2;
		// floor(x/10000) estimate via reciprocal, low by at most one
		recip = {13'b0, pb_q} * 39'd6710;
		qd = {14'b0, qe_q} * 26'd10000;
		rem = pb_q - qd;
		tot = mjd_q * 36'sd1440 + tod_q;
	end

	always_ff @(posedge clk) begin
		case (step_q)
			ST_IDLE: begin
				if (start) begin
					yd_q <= yd_n;
					mm1_q <= mm1_n;
					day_q <= job.rec.day;
					tod_q <= tod_n;
					bad_q <= job.rec.bad;
				end
			end
			ST_MUL: begin
				pa_q <= yd_q * 27'sd1461;
				pb_q <= {18'b0, mm1_q} * 26'd306001;
			end
			ST_DIV: begin
				a_q <= a_full[24:0];
				qe_q <= recip[37:26];
			end
			ST_FIX: begin
				b_q <= qe_q + {11'b0, (rem >= 26'd10000)};
			end
			ST_SUM: begin
				mjd_q <= a_q + 25'sd14956 + $signed({18'b0, day_q}) + $signed({13'b0, b_q});
			end
			ST_SCALE: begin
				utc_q <= bad_q ? '0 : tot[33:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			case (step_q)
				ST_IDLE:  if (start) step_q <= ST_MUL;
				ST_MUL:   step_q <= ST_DIV;
				ST_DIV:   step_q <= ST_FIX;
				ST_FIX:   step_q <= ST_SUM;
				ST_SUM:   step_q <= ST_SCALE;
				ST_SCALE: step_q <= ST_IDLE;
				default:  step_q <= ST_IDLE;
			endcase
			if (step_q == ST_SCALE) out_vld_q <= 1'b1;
			else if (pop) out_vld_q <= 1'b0;
		end
	end

	assign empty = !out_vld_q;
	assign utc_minutes = utc_q;
	assign malformed = bad_q;

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != ST_IDLE) |-> !job_pop)
		else $error("request taken while arithmetic busy");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_SCALE) |-> !out_vld_q)
		else $error("result register overwritten");

	a_fill_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(step_q == ST_SCALE))
		else $error("result appeared without a finished request");

endmodule
`default_nettype wire
